>>> rtl/shift_register_pwm_driver_assert.svh
// assertion macros used by the pwm driver serialiser
`ifndef SHIFT_REGISTER_PWM_DRIVER_ASSERT_SVH
`define SHIFT_REGISTER_PWM_DRIVER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SRPWM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/srpwm_pkg.sv
// shared types and constants of the shift register pwm driver
package srpwm_pkg;

	localparam int unsigned STORE_DEPTH_MAX = 32;
	localparam int unsigned BITS_PER_REG    = 8;
	localparam int unsigned DUTY_W          = 8;
	localparam int unsigned CHANNEL_W       = 5;
	localparam int unsigned SLOT_W          = 8;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = 8'd255;

	// item kinds
	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// duty write request towards the store
	typedef struct packed {
		logic                 en;
		logic [CHANNEL_W-1:0] channel;
		logic [DUTY_W-1:0]    duty;
	} duty_wr_t;

endpackage

>>> rtl/shift_register_pwm_driver.sv
// Multi-channel PWM driver for a chain of REGISTERS 8-bit shift registers.
// A set item (kind 0) writes one channel's duty; channels beyond the chain
// are dropped. A tick item (kind 1) sends one time slot as REGISTERS*8
// result beats, highest channel first, with latch high on the last beat; a
// channel's bit is 1 when its duty exceeds the slot index. After the accept,
// the channel down-counter forms one beat per cycle while the result side
// does not stall, reading one duty register and doing one 8-bit compare per
// beat. No new item is taken until the last beat is formed. slot_count may
// only be written while idle.
module shift_register_pwm_driver #(
	parameter int unsigned REGISTERS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              kind,
	input  logic [srpwm_pkg::CHANNEL_W-1:0]   channel,
	input  logic [srpwm_pkg::DUTY_W-1:0]      duty,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              serial_bit,
	output logic                              latch,
	input  logic                              cfg_wr_en,
	input  logic [srpwm_pkg::SLOT_W-1:0]      cfg_wr_data
);
	import srpwm_pkg::*;

	localparam int unsigned CH_W = $clog2(REGISTERS * BITS_PER_REG);

	logic [SLOT_W-1:0] slot_count_q;
	logic              accept;
	logic              start;
	logic              busy;
	duty_wr_t          wr;
	logic [CH_W-1:0]   rd_ch;
	logic [DUTY_W-1:0] rd_duty;

	// resolution register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
		end else if (cfg_wr_en) begin
			slot_count_q <= cfg_wr_data;
		end
	end

	// item beat decode
	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;
	assign start      = accept && (kind == KIND_TICK);
	assign wr.en      = accept && (kind == KIND_SET);
	assign wr.channel = channel;
	assign wr.duty    = duty;

	srpwm_duty_store #(
		.REGISTERS (REGISTERS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_ch   (rd_ch),
		.rd_duty (rd_duty)
	);

	srpwm_serialiser #(
		.REGISTERS (REGISTERS)
	) u_serialiser (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.slot_count   (slot_count_q),
		.rd_ch        (rd_ch),
		.rd_duty      (rd_duty),
		.busy         (busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.serial_bit   (serial_bit),
		.latch        (latch)
	);

endmodule

>>> rtl/srpwm_duty_store.sv
// per-channel duty registers with one write and one read port
module srpwm_duty_store #(
	parameter int unsigned REGISTERS = 4
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  srpwm_pkg::duty_wr_t                            wr,
	input  logic [$clog2(REGISTERS*srpwm_pkg::BITS_PER_REG)-1:0] rd_ch,
	output logic [srpwm_pkg::DUTY_W-1:0]                   rd_duty
);
	import srpwm_pkg::*;

	localparam int unsigned TOTAL = REGISTERS * BITS_PER_REG;
	localparam int unsigned DEPTH = (TOTAL < STORE_DEPTH_MAX) ? TOTAL : STORE_DEPTH_MAX;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [DUTY_W-1:0] duty_q [DEPTH];

	// duty registers, cleared on reset, writes beyond the chain dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				duty_q[i] <= '0;
			end
		end else if (wr.en && (32'(wr.channel) < DEPTH)) begin
			duty_q[wr.channel[AW-1:0]] <= wr.duty;
		end
	end

	// channels past the store always read as zero duty
	assign rd_duty = (32'(rd_ch) < DEPTH) ? duty_q[rd_ch[AW-1:0]] : '0;

endmodule

>>> rtl/srpwm_serialiser.sv
// bit-serial slot emitter: one channel compare and one output beat per cycle while the output is not stalled
`include "shift_register_pwm_driver_assert.svh"

module srpwm_serialiser #(
	parameter int unsigned REGISTERS = 4
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic [srpwm_pkg::SLOT_W-1:0]                   slot_count,
	output logic [$clog2(REGISTERS*srpwm_pkg::BITS_PER_REG)-1:0] rd_ch,
	input  logic [srpwm_pkg::DUTY_W-1:0]                   rd_duty,
	output logic                                           busy,
	output logic                                           result_valid,
	input  logic                                           result_ready,
	output logic                                           serial_bit,
	output logic                                           latch
);
	import srpwm_pkg::*;

	localparam int unsigned TOTAL = REGISTERS * BITS_PER_REG;
	localparam int unsigned CH_W  = $clog2(TOTAL);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(TOTAL - 1);

	logic              busy_q;
	logic [CH_W-1:0]   ch_q;
	logic [SLOT_W-1:0] slot_q;
	logic              out_valid_q;
	logic              bit_q;
	logic              latch_q;

	logic              load;
	logic              last;
	logic [SLOT_W:0]   slot_inc;
	logic [SLOT_W-1:0] slot_next;

	// next beat is formed when the output register is free or being drained
	assign load = busy_q && (!out_valid_q || result_ready);
	assign last = (ch_q == '0);

	// slot advance with wrap at the configured resolution
	assign slot_inc  = {1'b0, slot_q} + (SLOT_W+1)'(1);
	assign slot_next = (slot_inc >= {1'b0, slot_count}) ? '0 : slot_inc[SLOT_W-1:0];

	// channel counter runs from the top channel down to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
			slot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ch_q   <= CH_LAST;
		end else if (load) begin
			ch_q <= ch_q - CH_W'(1);
			if (last) begin
				busy_q <= 1'b0;
				slot_q <= slot_next;
			end
		end
	end

	// output beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			bit_q   <= (rd_duty > slot_q);
			latch_q <= last;
		end
	end

	assign rd_ch        = ch_q;
	assign busy         = busy_q;
	assign result_valid = out_valid_q;
	assign serial_bit   = bit_q;
	assign latch        = latch_q;

	// checks
	`SRPWM_ASSERT_NEXT(a_last_ends_tick, load && last, !busy_q && out_valid_q && latch_q, "tick did not end on latch beat")
	`SRPWM_ASSERT_NEXT(a_latch_only_last, load && !last, !latch_q, "latch marked before last beat")
	`SRPWM_ASSERT_NEXT(a_slot_wrapped, load && last, (slot_q == '0) || (slot_q < slot_count), "slot index past resolution")
	`SRPWM_ASSERT_SAME(a_start_idle, start, !busy_q && !load, "tick started while a slot is in flight")

endmodule
